// ===== hw/rtl/rme_pkg.sv =====
`default_nettype none

package rme_pkg;

  // Step counter width of the sequencer program
  localparam int unsigned PC_WIDTH = 3;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  typedef logic [PC_WIDTH-1:0] pc_t;

  // Program steps
  localparam pc_t STEP_WAIT  = 3'd0;
  localparam pc_t STEP_LOOP  = 3'd1;
  localparam pc_t STEP_TEST  = 3'd2;
  localparam pc_t STEP_MUL   = 3'd3;
  localparam pc_t STEP_SQR   = 3'd4;
  localparam pc_t STEP_EMIT  = 3'd5;

  localparam logic KIND_DECRYPT = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODULUS     = 2'd0,
    REG_PUBLIC_EXP  = 2'd1,
    REG_PRIVATE_EXP = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_WAIT,
    UOP_MUL,
    UOP_SQR,
    UOP_EMIT
  } uop_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_LOOP_END,
    COND_BIT_CLEAR
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

  // Microcode store: one control word per step
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t word;
    unique case (pc)
      STEP_WAIT: word = '{op: UOP_WAIT, cond: COND_NONE,      target: STEP_WAIT};
      STEP_LOOP: word = '{op: UOP_NOP,  cond: COND_LOOP_END,  target: STEP_EMIT};
      STEP_TEST: word = '{op: UOP_NOP,  cond: COND_BIT_CLEAR, target: STEP_SQR};
      STEP_MUL:  word = '{op: UOP_MUL,  cond: COND_NONE,      target: STEP_WAIT};
      STEP_SQR:  word = '{op: UOP_SQR,  cond: COND_ALWAYS,    target: STEP_LOOP};
      STEP_EMIT: word = '{op: UOP_EMIT, cond: COND_ALWAYS,    target: STEP_WAIT};
      default:   word = '{op: UOP_NOP,  cond: COND_ALWAYS,    target: STEP_WAIT};
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rme_modmul.sv =====
`default_nettype none

module rme_modmul #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output rme_pkg::mm_status_t      status,
  output logic [OPERAND_WIDTH-1:0] product
);
  import rme_pkg::*;

  localparam int unsigned ProdWidth = 2 * OPERAND_WIDTH;
  localparam int unsigned CntWidth  = $clog2(ProdWidth + 1);

  logic [ProdWidth-1:0]     prod;
  logic [OPERAND_WIDTH-1:0] rem;
  logic [CntWidth-1:0]      cnt;
  logic                     busy;
  logic                     done;
  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH:0]   diff;

  // Restoring reduction: shift in one product bit, subtract modulus if it fits
  assign trial = {rem, prod[ProdWidth-1]};
  assign diff  = trial - {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(ProdWidth);
      end else if (busy) begin
        cnt <= cnt - CntWidth'(1);
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      prod <= ProdWidth'(a) * ProdWidth'(b);
      rem  <= '0;
    end else if (busy) begin
      prod <= prod << 1;
      rem  <= diff[OPERAND_WIDTH] ? trial[OPERAND_WIDTH-1:0] : diff[OPERAND_WIDTH-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign product     = rem;

endmodule

`default_nettype wire

// ===== hw/rtl/rsa_modular_exponentiation_top.sv =====
// Modular exponentiation engine: result = value ^ exponent mod modulus.
//
// Request channel (req_valid/req_ready, fields kind and value): kind 0
// selects the public exponent, kind 1 the private one. One beat in gives
// exactly one beat out on the response channel (rsp_valid/rsp_ready, field
// result). An exponent of zero gives 1; a modulus below two gives 0.
//
// Configuration: cfg_we with cfg_index 0 (modulus), 1 (public exponent) or
// 2 (private exponent) writes cfg_data; other indices are dropped.
// Write only while no request is in flight.
//
// Operation: a microcoded sequencer walks the exponent from its LSB on one
// shared modular multiplier; each multiply or square is a product step,
// 2W reduction steps and a hand-back, W = OPERAND_WIDTH. rsp_valid rises
// at the same edge at which req_ready returns. The result sits in an
// output register, so a stalled receiver blocks the sequencer only when a
// second result is ready while the first is unclaimed. Reset restores
// modulus 2 and both exponents 1, and clears rsp_valid.
`default_nettype none

module rsa_modular_exponentiation_top #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [rme_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [OPERAND_WIDTH-1:0]              cfg_data,
  // request channel
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  logic                                  kind,
  input  logic [OPERAND_WIDTH-1:0]              value,
  // response channel
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready,
  output logic [OPERAND_WIDTH-1:0]              result
);
  import rme_pkg::*;

  // Configuration registers
  logic [OPERAND_WIDTH-1:0] modulus;
  logic [OPERAND_WIDTH-1:0] public_exponent;
  logic [OPERAND_WIDTH-1:0] private_exponent;

  // Sequencer
  pc_t    pc;
  pc_t    pc_next;
  ucode_t ctrl;
  logic   stall;
  logic   jump;

  // Datapath
  logic [OPERAND_WIDTH-1:0] acc;
  logic [OPERAND_WIDTH-1:0] base;
  logic [OPERAND_WIDTH-1:0] expo;
  logic                     issued;
  logic                     mod_small;

  // Multiplier interface
  logic                     mm_start;
  logic [OPERAND_WIDTH-1:0] mm_a;
  mm_status_t               mm_status;
  logic [OPERAND_WIDTH-1:0] mm_result;

  assign ctrl      = ucode_rom(pc);
  assign mod_small = modulus < OPERAND_WIDTH'(2);

  // Configuration writes; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= OPERAND_WIDTH'(2);
      public_exponent  <= OPERAND_WIDTH'(1);
      private_exponent <= OPERAND_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:     modulus          <= cfg_data;
        REG_PUBLIC_EXP:  public_exponent  <= cfg_data;
        REG_PRIVATE_EXP: private_exponent <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Next step: hold on stall, else branch or fall through
  always_comb begin
    unique case (ctrl.op)
      UOP_WAIT:         stall = !req_valid;
      UOP_MUL, UOP_SQR: stall = !mm_status.done;
      UOP_EMIT:         stall = rsp_valid && !rsp_ready;
      UOP_NOP:          stall = 1'b0;
      default:          stall = 1'b0;
    endcase

    unique case (ctrl.cond)
      COND_NONE:      jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_LOOP_END:  jump = (expo == '0) || mod_small;
      COND_BIT_CLEAR: jump = !expo[0];
      default:        jump = 1'b0;
    endcase

    if (stall) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + pc_t'(1);
    end
  end

  // Control outputs of the current step
  always_comb begin
    req_ready = (ctrl.op == UOP_WAIT);
    mm_start  = (ctrl.op == UOP_MUL || ctrl.op == UOP_SQR) && !issued;
    // multiply uses the running result, square uses the base twice
    mm_a      = (ctrl.op == UOP_MUL) ? acc : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_WAIT;
      issued    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (mm_start) begin
        issued <= 1'b1;
      end else if (mm_status.done) begin
        issued <= 1'b0;
      end
      if (ctrl.op == UOP_EMIT && !stall) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      UOP_WAIT: begin
        if (req_valid) begin
          base <= value;
          expo <= (kind == KIND_DECRYPT) ? private_exponent : public_exponent;
          acc  <= mod_small ? '0 : OPERAND_WIDTH'(1);
        end
      end
      UOP_MUL: begin
        if (mm_status.done) begin
          acc <= mm_result;
        end
      end
      UOP_SQR: begin
        if (mm_status.done) begin
          base <= mm_result;
          expo <= expo >> 1;
        end
      end
      UOP_EMIT: begin
        if (!stall) begin
          result <= acc;
        end
      end
      default: ;
    endcase
  end

  rme_modmul #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (base),
    .m       (modulus),
    .status  (mm_status),
    .product (mm_result)
  );

  // The multiplier only hands back while the sequencer waits on it
  a_done_in_op: assert property (@(posedge clk) disable iff (rst)
    mm_status.done |-> (ctrl.op == UOP_MUL || ctrl.op == UOP_SQR))
    else $error("multiplier result arrived outside a multiply step");

  // A new request never lands while an operation is outstanding
  a_idle_on_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (!issued && !mm_status.busy))
    else $error("request accepted while the multiplier is in use");

  // A request beat always moves the program to the loop head
  a_beat_to_loop: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (pc == STEP_LOOP))
    else $error("request beat did not start the exponent loop");

  // Never launch an operation on a busy multiplier
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_status.busy)
    else $error("multiplier started while busy");

endmodule

`default_nettype wire

// ===== verif/modexp_checker.sv =====
`timescale 1ns / 100ps

module modexp_checker #(
  parameter int unsigned W = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rme_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [W-1:0]                       cfg_data,
  input  logic                               req_valid,
  input  logic                               req_ready,
  input  logic                               kind,
  input  logic [W-1:0]                       value,
  input  logic                               rsp_valid,
  input  logic                               rsp_ready,
  input  logic [W-1:0]                       result,
  output int                                 failures,
  output int                                 pending
);

  import rme_pkg::*;

  typedef struct packed {
    logic         kind_bit;
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic [W-1:0] modulus;
    logic [W-1:0] power;
  } awaited_t;

  logic [W-1:0] modulus_q;
  logic [W-1:0] public_exp_q;
  logic [W-1:0] private_exp_q;
  awaited_t     awaited_results[$];
  int           fail_count;

  // Right-to-left square and multiply at double width
  function automatic logic [W-1:0] mod_power(input logic [W-1:0] base,
                                             input logic [W-1:0] exponent,
                                             input logic [W-1:0] modulus);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] sq;
    logic [2*W-1:0] mdl;
    logic [W-1:0]   bits_left;
    if (modulus < 2) return '0;
    acc = (2*W)'(1);
    sq = (2*W)'(base);
    mdl = (2*W)'(modulus);
    bits_left = exponent;
    for (int i = 0; i < W && bits_left != 0; i++) begin
      if (bits_left[0]) acc = (acc * sq) % mdl;
      sq = (sq * sq) % mdl;
      bits_left = bits_left >> 1;
    end
    return acc[W-1:0];
  endfunction

  always @(posedge clk) begin : track
    awaited_t     head;
    awaited_t     entry;
    logic [W-1:0] chosen_exp;
    if (rst) begin
      modulus_q <= W'(2);
      public_exp_q <= W'(1);
      private_exp_q <= W'(1);
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:     modulus_q <= cfg_data;
          REG_PUBLIC_EXP:  public_exp_q <= cfg_data;
          REG_PRIVATE_EXP: private_exp_q <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing awaited: expected none, got %0d",
                   $time, result);
        end else begin
          head = awaited_results.pop_front();
          if (result !== head.power) begin
            fail_count++;
            $display("%0t: kind %0d value %0d exp %0d mod %0d: expected %0d, got %0d",
                     $time, head.kind_bit, head.base, head.exponent, head.modulus,
                     head.power, result);
          end
        end
      end
      if (req_valid && req_ready) begin
        chosen_exp = (kind == KIND_DECRYPT) ? private_exp_q : public_exp_q;
        entry.kind_bit = kind;
        entry.base = value;
        entry.exponent = chosen_exp;
        entry.modulus = modulus_q;
        entry.power = mod_power(value, chosen_exp, modulus_q);
        awaited_results.push_back(entry);
      end
    end
    failures <= fail_count;
    pending <= awaited_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  import rme_pkg::*;

  localparam int unsigned W = 16;
  localparam int unsigned ITEM_TARGET = 1150;
  // Long receiver hold-off: enough for the block to finish one result, hold
  // it in the output register, finish a second and stall its request side
  localparam int unsigned RX_HOLD_CYCLES = 4000;
  // Cycles with no beat on either channel before the run is declared hung;
  // covers the hold-off above plus a worst-case exponent of all ones
  localparam int unsigned STALL_LIMIT = 25000;
  // Quiet time at the end to catch stray result beats
  localparam int unsigned SETTLE_CYCLES = 1200;
  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [W-1:0]               cfg_data;
  logic                       req_valid;
  logic                       req_ready;
  logic                       kind;
  logic [W-1:0]               value;
  logic                       rsp_valid;
  logic                       rsp_ready;
  logic [W-1:0]               result;

  int          failures;
  int          pending;
  int unsigned items_sent = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned quiet_cycles = 0;

  rsa_modular_exponentiation_top #(
    .OPERAND_WIDTH(W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .kind     (kind),
    .value    (value),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .result   (result)
  );

  modexp_checker #(
    .W(W)
  ) scoreboard (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .kind     (kind),
    .value    (value),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .result   (result),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: restart the count on any beat, give up once it runs out
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly no gap at all, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(40, 250);
  endfunction

  // Extremes and out-of-range moduli now and then, small ones often so
  // that values at or above the modulus come up
  function automatic logic [W-1:0] pick_modulus();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return W'(1);
    if (r < 10) return W'(2);
    if (r < 14) return '1;
    if (r < 35) return W'($urandom_range(3, 255));
    return W'($urandom_range(3, (1 << W) - 1));
  endfunction

  // Keep most exponents short: each significant bit costs a square and each
  // set bit a multiply, so full-width ones stay rare
  function automatic logic [W-1:0] pick_exponent();
    int unsigned r;
    int unsigned bits;
    logic [31:0] raw;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 15) return W'(1);
    if (r < 22) bits = $urandom_range(11, W);
    else bits = $urandom_range(2, 10);
    raw = $urandom;
    raw = raw & ((32'd1 << bits) - 32'd1);
    raw[bits-1] = 1'b1;
    return raw[W-1:0];
  endfunction

  function automatic logic [W-1:0] pick_value(input logic [W-1:0] mdl);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return W'(1);
        default: return '1;
      endcase
    end
    if (r < 30 && mdl > 1) return W'($urandom_range(0, mdl - 1));
    // values at and just around the modulus exercise the first reduction
    if (r < 38) return W'(mdl + $urandom_range(0, 2) - 1);
    return W'($urandom);
  endfunction

  // Offer one beat and hold it until the block takes it
  task automatic send_item(input logic k, input logic [W-1:0] v);
    req_valid <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every awaited result has come back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Only ever called with the block idle
  task automatic configure(input logic [W-1:0] mdl, input logic [W-1:0] pub,
                           input logic [W-1:0] priv, input bit touch_spare);
    write_reg(REG_MODULUS, mdl);
    write_reg(REG_PUBLIC_EXP, pub);
    write_reg(REG_PRIVATE_EXP, priv);
    if (touch_spare) write_reg(REG_SPARE, W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Receiver: random ready pattern, plus the long hold-off on request
  initial begin : receiver
    int unsigned r;
    int unsigned len;
    int unsigned i;
    rsp_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_served < hold_requests) begin
        rsp_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          rsp_ready <= 1'b1;
          len = $urandom_range(100, 400);
        end else if (r < 60) begin
          rsp_ready <= 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 95) begin
          rsp_ready <= 1'b0;
          len = $urandom_range(1, 4);
        end else begin
          rsp_ready <= 1'b0;
          len = $urandom_range(30, 300);
        end
        // always wait for a clock edge before the next pick, so ready is set once per step
        i = 0;
        do begin
          @(posedge clk);
          i++;
        end while (i < len && holds_served >= hold_requests);
      end
    end
  end

  // Sender: reset, directed beats, then random phases
  initial begin : sender
    logic [W-1:0] mdl;
    int unsigned  count;
    int unsigned  phase;
    int unsigned  i;
    bit           burst;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODULUS;
    cfg_data <= '0;
    req_valid <= 1'b0;
    kind <= 1'b0;
    value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: modulus two, both exponents one
    send_item(1'b0, '0);
    idle_sender(pick_gap());
    send_item(KIND_DECRYPT, '1);
    send_item(1'b0, 16'h5555);
    send_item(KIND_DECRYPT, 16'hAAAA);
    drain();

    // Textbook key pair: encrypt 65, then decrypt its cipher back
    configure(16'd3233, 16'd17, 16'd2753, 1'b0);
    send_item(1'b0, 16'd65);
    send_item(KIND_DECRYPT, 16'd2790);
    idle_sender(pick_gap());
    send_item(1'b0, '0);
    send_item(KIND_DECRYPT, 16'd3232);
    send_item(1'b0, 16'd3233);
    drain();

    // Largest modulus; exponent zero and exponent of all ones
    configure('1, '0, '1, 1'b0);
    send_item(1'b0, 16'd1234);
    send_item(KIND_DECRYPT, '1);
    send_item(KIND_DECRYPT, 16'hFFFE);
    send_item(KIND_DECRYPT, 16'd2);
    drain();

    // Modulus zero and one give zero whatever the exponent
    configure('0, 16'd5, 16'd3, 1'b0);
    send_item(1'b0, 16'd7);
    send_item(KIND_DECRYPT, '1);
    drain();
    configure(16'd1, '0, '1, 1'b0);
    send_item(1'b0, 16'd9);
    send_item(KIND_DECRYPT, 16'd100);
    drain();

    // Smallest valid modulus; the spare index must leave it untouched
    configure(16'd2, '1, '0, 1'b1);
    send_item(1'b0, 16'd3);
    send_item(KIND_DECRYPT, 16'd3);
    send_item(1'b0, '1);
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      mdl = pick_modulus();
      configure(mdl, pick_exponent(), pick_exponent(), $urandom_range(0, 4) == 0);
      // the third phase keeps the request side busy through a long hold-off
      burst = ($urandom_range(0, 3) == 0) || (phase == 2);
      count = $urandom_range(8, 40);
      if (phase == 2) hold_requests++;
      for (i = 0; i < count && items_sent < ITEM_TARGET; i++) begin
        send_item(1'($urandom_range(0, 1)), pick_value(mdl));
        if (!burst) idle_sender(pick_gap());
      end
      drain();
      phase++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
